// File: rtl/owrs_pkg.sv
`timescale 1ns / 1ps

package owrs_pkg;

    // Item kinds carried on the action field.
    localparam logic ACT_PASS_START = 1'b0;
    localparam logic ACT_BIT_PAIR   = 1'b1;

    // Bit pair codes: bit 0 is the id bit, bit 1 its complement.
    localparam logic [1:0] PAIR_CONFLICT = 2'b00;
    localparam logic [1:0] PAIR_NONE     = 2'b11;

    // Width of the destination buffer size register.
    localparam int BUF_W = 16;

    // Result status codes.
    typedef enum logic [2:0] {
        ST_OK          = 3'd0,
        ST_NO_PRESENCE = 3'd1,
        ST_NO_DEVICE   = 3'd2,
        ST_OVERFLOW    = 3'd3,
        ST_SEQUENCE    = 3'd4
    } status_t;

    // One input request as held in the input register.
    typedef struct packed {
        logic       action;
        logic       new_search;
        logic       presence;
        logic [1:0] bit_pair;
    } item_t;

    // Fixed-width part of one result.
    typedef struct packed {
        logic       write_bit;
        logic       rom_complete;
        logic       rom_stored;
        logic [7:0] rom_count;
        logic       search_more;
        status_t    status;
    } result_t;

endpackage

// File: rtl/owrs_in_reg.sv
`timescale 1ns / 1ps

module owrs_in_reg
(
    input  logic           clk,
    input  logic           rst_n,
    input  logic           in_valid,
    output logic           in_ready,
    input  owrs_pkg::item_t in_item,
    input  logic           advance,
    output logic           item_valid,
    output owrs_pkg::item_t item
);

    logic            valid_reg;
    logic            valid_next;
    owrs_pkg::item_t item_reg;
    logic            take;

    // The stage takes a new request when empty or when its content moves on.
    assign in_ready = !valid_reg || advance;
    assign take     = in_valid && in_ready;

    always_comb
    begin
        if (take)
        begin
            valid_next = 1'b1;
        end
        else if (advance)
        begin
            valid_next = 1'b0;
        end
        else
        begin
            valid_next = valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    // Payload needs no reset.
    always_ff @(posedge clk)
    begin
        if (take)
        begin
            item_reg <= in_item;
        end
    end

    assign item_valid = valid_reg;
    assign item       = item_reg;

endmodule

// File: rtl/owrs_engine.sv
`timescale 1ns / 1ps

module owrs_engine
#(
    parameter int ROM_BITS = 64
)
(
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    cfg_wr_en,
    input  logic [15:0]             cfg_wr_data,
    input  logic                    fire,
    input  owrs_pkg::item_t         item,
    output owrs_pkg::result_t       res,
    output logic [ROM_BITS-1:0]     rom_next
);

    localparam int POS_W     = $clog2(ROM_BITS);
    localparam int ROM_BYTES = (ROM_BITS + 7) / 8;
    localparam int NEED_W    = owrs_pkg::BUF_W + 1;

    logic [owrs_pkg::BUF_W-1:0] buf_reg;
    logic [ROM_BITS-1:0]        mask_reg;
    logic [ROM_BITS-1:0]        mask_next;
    logic [ROM_BITS-1:0]        rom_reg;
    logic [POS_W-1:0]           pos_reg;
    logic [POS_W-1:0]           pos_next;
    logic [7:0]                 cnt_reg;
    logic [7:0]                 cnt_next;
    logic                       active_reg;
    logic                       active_next;

    logic [ROM_BITS-1:0]        here;
    logic [ROM_BITS-1:0]        above;
    logic                       higher;
    logic                       wb;
    logic [NEED_W-1:0]          need;

    // One-hot of the current position and the positions above it.
    always_comb
    begin
        for (int i = 0; i < ROM_BITS; i++)
        begin
            here[i]  = (POS_W'(i) == pos_reg);
            above[i] = (POS_W'(i) > pos_reg);
        end
    end

    assign higher = |(mask_reg & above);

    // Buffer space needed once the current ROM is counted.
    assign need = ({{(NEED_W-8){1'b0}}, cnt_reg} + NEED_W'(1)) * NEED_W'(ROM_BYTES);

    // Direction bit: the id bit when the pair agrees, else follow or take the branch at a discrepancy.
    always_comb
    begin
        if (item.bit_pair == owrs_pkg::PAIR_CONFLICT)
        begin
            wb = higher ? !mask_reg[pos_reg] : mask_reg[pos_reg];
        end
        else
        begin
            wb = item.bit_pair[0];
        end
    end

    // Next state and result of the current request.
    always_comb
    begin
        mask_next        = mask_reg;
        rom_next         = rom_reg;
        pos_next         = pos_reg;
        cnt_next         = cnt_reg;
        active_next      = active_reg;
        res.write_bit    = 1'b0;
        res.rom_complete = 1'b0;
        res.rom_stored   = 1'b0;
        res.status       = owrs_pkg::ST_OK;

        if (item.action == owrs_pkg::ACT_PASS_START)
        begin
            if (item.new_search)
            begin
                mask_next = '0;
                cnt_next  = '0;
            end
            if (!item.presence)
            begin
                cnt_next    = '0;
                active_next = 1'b0;
                res.status  = owrs_pkg::ST_NO_PRESENCE;
            end
            else
            begin
                rom_next    = '0;
                pos_next    = '0;
                active_next = 1'b1;
            end
        end
        else if (!active_reg)
        begin
            res.status = owrs_pkg::ST_SEQUENCE;
        end
        else if (item.bit_pair == owrs_pkg::PAIR_NONE)
        begin
            cnt_next    = '0;
            active_next = 1'b0;
            res.status  = owrs_pkg::ST_NO_DEVICE;
        end
        else
        begin
            res.write_bit = wb;
            if (item.bit_pair == owrs_pkg::PAIR_CONFLICT && !higher)
            begin
                mask_next = mask_reg ^ here;
            end
            if (wb)
            begin
                rom_next = rom_reg | here;
            end
            if (pos_reg == POS_W'(ROM_BITS - 1))
            begin
                res.rom_complete = 1'b1;
                res.rom_stored   = (need <= {1'b0, buf_reg});
                active_next      = 1'b0;
                pos_next         = '0;
                cnt_next         = cnt_reg + 8'd1;
                if (cnt_next == 8'd0)
                begin
                    res.status = owrs_pkg::ST_OVERFLOW;
                end
            end
            else
            begin
                pos_next = pos_reg + POS_W'(1);
            end
        end

        res.rom_count   = cnt_next;
        res.search_more = (res.status != owrs_pkg::ST_OVERFLOW) && (|mask_next);
    end

    // Search state advances once per request.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mask_reg   <= '0;
            rom_reg    <= '0;
            pos_reg    <= '0;
            cnt_reg    <= '0;
            active_reg <= 1'b0;
        end
        else if (fire)
        begin
            mask_reg   <= mask_next;
            rom_reg    <= rom_next;
            pos_reg    <= pos_next;
            cnt_reg    <= cnt_next;
            active_reg <= active_next;
        end
    end

    // Destination buffer size register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            buf_reg <= '1;
        end
        else if (cfg_wr_en)
        begin
            buf_reg <= cfg_wr_data;
        end
    end

    // A finished ROM always ends the pass.
    a_complete_ends_pass: assert property (@(posedge clk) disable iff (!rst_n)
        fire && res.rom_complete |=> !active_reg && pos_reg == '0)
        else $error("pass still active after a completed ROM");

    // Overflow reports an empty count and no further pass.
    a_overflow_result: assert property (@(posedge clk) disable iff (!rst_n)
        fire && res.status == owrs_pkg::ST_OVERFLOW
        |-> res.rom_count == 8'd0 && !res.search_more && res.rom_complete)
        else $error("overflow result inconsistent");

    // An out-of-sequence bit pair leaves the search state alone.
    a_sequence_no_change: assert property (@(posedge clk) disable iff (!rst_n)
        fire && res.status == owrs_pkg::ST_SEQUENCE
        |=> $stable(mask_reg) && $stable(cnt_reg) && $stable(rom_reg) && !active_reg)
        else $error("state changed on an out-of-sequence bit pair");

    // Only bit pairs during an active pass drive a direction bit.
    a_write_bit_source: assert property (@(posedge clk) disable iff (!rst_n)
        fire && res.write_bit |-> item.action == owrs_pkg::ACT_BIT_PAIR && active_reg)
        else $error("direction bit outside an active pass");

endmodule

// File: rtl/owrs_out_reg.sv
`timescale 1ns / 1ps

module owrs_out_reg
#(
    parameter int ROM_BITS = 64
)
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                item_valid,
    output logic                advance,
    input  owrs_pkg::result_t   res,
    input  logic [ROM_BITS-1:0] rom_in,
    output logic                out_valid,
    input  logic                out_ready,
    output owrs_pkg::result_t   out_res,
    output logic [ROM_BITS-1:0] out_rom
);

    logic                valid_reg;
    logic                valid_next;
    owrs_pkg::result_t   res_reg;
    logic [ROM_BITS-1:0] rom_reg;

    // A result moves in when the register is empty or being emptied.
    assign advance = item_valid && (!valid_reg || out_ready);

    always_comb
    begin
        if (advance)
        begin
            valid_next = 1'b1;
        end
        else if (out_ready)
        begin
            valid_next = 1'b0;
        end
        else
        begin
            valid_next = valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    // Result payload is held while the receiver stalls.
    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            res_reg <= res;
            rom_reg <= rom_in;
        end
    end

    assign out_valid = valid_reg;
    assign out_res   = res_reg;
    assign out_rom   = rom_reg;

endmodule

// File: rtl/onewire_rom_search_step_unit.sv
`timescale 1ns / 1ps
// 1-Wire ROM search decision unit.
// Input channel (in_valid/in_ready) carries one request per bus event: a pass
// start (action 0, with new_search and presence) or a received bit pair
// (action 1, bit_pair). Output channel (out_valid/out_ready) returns exactly
// one result per request: the direction bit to write, the ROM built so far,
// completion and storage flags, the device count, whether another pass is
// needed and a status code.
// A request accepted into the input register passes through the decision logic
// and is loaded into the result register, raising out_valid. One request is
// taken every cycle while results are drained, since the search state is
// updated in the same cycle that a result is registered.
// When the receiver stalls, the result register holds and the input register
// fills; in_ready falls only once both are occupied.
// The buffer size register is written through cfg_wr_en/cfg_wr_data.
// Reset clears the branch mask, ROM, bit position and device count, leaves
// the pass idle and sets the buffer size to 65535 bytes.

module onewire_rom_search_step_unit
#(
    parameter int ROM_BITS = 64
)
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                cfg_wr_en,
    input  logic [15:0]         cfg_wr_data,
    input  logic                in_valid,
    output logic                in_ready,
    input  logic                action,
    input  logic                new_search,
    input  logic                presence,
    input  logic [1:0]          bit_pair,
    output logic                out_valid,
    input  logic                out_ready,
    output logic                write_bit,
    output logic                rom_complete,
    output logic [ROM_BITS-1:0] rom_value,
    output logic                rom_stored,
    output logic [7:0]          rom_count,
    output logic                search_more,
    output logic [2:0]          status
);

    owrs_pkg::item_t     in_item;
    owrs_pkg::item_t     item;
    logic                item_valid;
    logic                advance;
    owrs_pkg::result_t   res;
    owrs_pkg::result_t   out_res;
    logic [ROM_BITS-1:0] rom_next;

    assign in_item.action     = action;
    assign in_item.new_search = new_search;
    assign in_item.presence   = presence;
    assign in_item.bit_pair   = bit_pair;

    // Input register.
    owrs_in_reg u_in_reg
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_ready   (in_ready),
        .in_item    (in_item),
        .advance    (advance),
        .item_valid (item_valid),
        .item       (item)
    );

    // Search state and decision logic.
    owrs_engine #(.ROM_BITS(ROM_BITS)) u_engine
    (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .fire        (advance),
        .item        (item),
        .res         (res),
        .rom_next    (rom_next)
    );

    // Result register.
    owrs_out_reg #(.ROM_BITS(ROM_BITS)) u_out_reg
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .item_valid (item_valid),
        .advance    (advance),
        .res        (res),
        .rom_in     (rom_next),
        .out_valid  (out_valid),
        .out_ready  (out_ready),
        .out_res    (out_res),
        .out_rom    (rom_value)
    );

    assign write_bit    = out_res.write_bit;
    assign rom_complete = out_res.rom_complete;
    assign rom_stored   = out_res.rom_stored;
    assign rom_count    = out_res.rom_count;
    assign search_more  = out_res.search_more;
    assign status       = out_res.status;

endmodule
